### hw/rtl/seq_pkg.sv
// Shared types, constants and codes of the sorted event queue.
`default_nettype none

package seq_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int ID_BITS     = 14;
  localparam int TIME_BITS   = 16;
  localparam int DELAY_BITS  = 8;
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Match reduction: first level ORs groups of this many cells.
  localparam int GROUP_SIZE  = 32;
  localparam int NUM_GROUPS  = (QUEUE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POP    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FIND   = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  localparam logic KIND_TX = 1'b0;

  localparam int IN_FIELDS_W  = OP_BITS + ID_BITS + 1 + TIME_BITS + DELAY_BITS;
  localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_BITS + 1 + 1 + TIME_BITS + ID_BITS + 1 + CNT_BITS;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [TIME_BITS-1:0] tm;
    logic [ID_BITS-1:0]   ident;
    logic                 kind;
  } data_t;

  typedef struct packed {
    logic  occ;
    data_t data;
  } entry_t;

  // Broadcast to every cell in the accept cycle.
  // front: the new event goes in front of the head, so every slot shifts.
  typedef struct packed {
    logic                 ins;
    logic                 pop;
    logic                 find;
    logic                 front;
    logic [TIME_BITS-1:0] tm;
    logic [ID_BITS-1:0]   ident;
    logic                 kind;
  } cmd_t;

  // Input word, lowest field in the lowest bits.
  typedef struct packed {
    logic [IN_W-IN_FIELDS_W-1:0] pad;
    logic [DELAY_BITS-1:0]       delay;
    logic [TIME_BITS-1:0]        now;
    logic                        kind;
    logic [ID_BITS-1:0]          ident;
    logic [OP_BITS-1:0]          operation;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-OUT_FIELDS_W-1:0] pad;
    logic [CNT_BITS-1:0]           occupancy;
    logic                          event_kind;
    logic [ID_BITS-1:0]            event_identity;
    logic [TIME_BITS-1:0]          event_time;
    logic                          event_valid;
    logic                          found;
    logic [STATUS_BITS-1:0]        status;
  } out_word_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_event_queue.sv
// Top level of the sorted event queue: cell chain, match reduction and output word.
// An input word is taken only in the idle phase, so a new word waits until the last result
//   is loaded; the match reduction registers flags in the cells, then 32-cell group hits,
//   then takes the final OR; insert and pop shift the chain at once.
// Reset (rst, synchronous, active high) empties the queue and clears both handshakes;
//   slot payloads are not cleared, as only occupied slots are ever read.
`default_nettype none

module sorted_event_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // operation[1:0], identity[15:2], kind[16], now[32:17], delay[40:33], zero pad
  input  wire logic [seq_pkg::IN_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // status[1:0], found[2], event_valid[3], event_time[19:4],
  // event_identity[33:20], event_kind[34], occupancy[45:35], zero pad
  output logic [seq_pkg::OUT_W-1:0]     m_tdata
);
  import seq_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_REDUCE = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic [1:0]          phase;
  logic [1:0]          phase_next;
  logic [CNT_BITS-1:0] count;
  in_word_t            in_word;
  logic                accept;
  logic                full;
  logic                empty;
  logic [TIME_BITS:0]  sum;
  logic [TIME_BITS-1:0] fire_tm;
  cmd_t                cmd;

  // Held from the accept cycle until the result word is built.
  logic [OP_BITS-1:0]     op_q;
  logic [STATUS_BITS-1:0] status_q;
  logic                   popped_q;
  data_t                  pop_data;

  entry_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] opens;
  logic [QUEUE_DEPTH-1:0] match_flags;
  logic                   tree_found;
  logic                   load_out;
  out_word_t              out_next;

  assign in_word  = in_word_t'(s_tdata);
  assign s_tready = !rst && (phase == PH_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  // Fire time saturates at the top of the time range.
  always_comb begin
    sum     = {1'b0, in_word.now} + (TIME_BITS + 1)'(in_word.delay);
    fire_tm = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  end

  always_comb begin
    cmd.ins   = accept && (in_word.operation == OP_INSERT) && !full;
    cmd.pop   = accept && (in_word.operation == OP_POP) && !empty;
    cmd.find  = accept && (in_word.operation == OP_FIND);
    cmd.front = entries[0].occ && (entries[0].data.tm >= fire_tm);
    cmd.tm    = fire_tm;
    cmd.ident = in_word.ident;
    cmd.kind  = in_word.kind;
  end

  // Chain: slot 0 is the head; inserts shift rightwards, pops leftwards.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_open;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_open  = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_open  = opens[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    seq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .head_cell   ((i == 0) ? 1'b1 : 1'b0),
      .cmd         (cmd),
      .left_entry  (left_entry),
      .left_open   (left_open),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .slot_open   (opens[i]),
      .match       (match_flags[i])
    );
  end

  seq_or_tree u_or_tree (
    .clk    (clk),
    .enable (phase == PH_REDUCE),
    .match  (match_flags),
    .found  (tree_found)
  );

  // Occupancy tracks the chain's filled slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins) begin
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      count <= count - 1'b1;
    end
  end

  // Capture the operation and the outgoing head in the accept cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= in_word.operation;
      popped_q <= cmd.pop;
      pop_data <= entries[0].data;
      if (in_word.operation == OP_INSERT && full) begin
        status_q <= ST_FULL;
      end else if (in_word.operation == OP_POP && empty) begin
        status_q <= ST_EMPTY;
      end else begin
        status_q <= ST_OK;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:   if (accept) phase_next = PH_REDUCE;
      PH_REDUCE: phase_next = PH_DONE;
      PH_DONE:   if (load_out) phase_next = PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Hold the finished result until the output register is free.
  assign load_out = (phase == PH_DONE) && (!m_tvalid || m_tready);

  // Report the popped entry, else the head after the operation, else zeros.
  always_comb begin
    out_next           = '0;
    out_next.status    = status_q;
    out_next.found     = (op_q == OP_FIND) && tree_found;
    out_next.occupancy = count;
    if (popped_q) begin
      out_next.event_valid    = 1'b1;
      out_next.event_time     = pop_data.tm;
      out_next.event_identity = pop_data.ident;
      out_next.event_kind     = pop_data.kind;
    end else if (entries[0].occ) begin
      out_next.event_valid    = 1'b1;
      out_next.event_time     = entries[0].data.tm;
      out_next.event_identity = entries[0].data.ident;
      out_next.event_kind     = entries[0].data.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= out_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/seq_cell.sv
// One slot of the time-ordered shift chain.
`default_nettype none

module seq_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_cell,
  input  wire seq_pkg::cmd_t  cmd,
  input  wire seq_pkg::entry_t left_entry,
  input  wire logic           left_open,
  input  wire seq_pkg::entry_t right_entry,
  output seq_pkg::entry_t     entry,
  output logic                slot_open,
  output logic                match
);
  import seq_pkg::*;

  logic  occ;
  data_t data;
  logic  later;
  logic  take_new;
  logic  take_left;

  assign entry = '{occ: occ, data: data};

  // Head slot yields on an equal or later time, the others only on a strictly later time,
  // unless the new event goes in front, when every slot yields.
  always_comb begin
    later     = head_cell ? (data.tm >= cmd.tm) : (cmd.front || (data.tm > cmd.tm));
    slot_open = !occ || later;
    take_new  = cmd.ins && slot_open && (head_cell || !left_open);
    take_left = cmd.ins && slot_open && !head_cell && left_open;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (take_new) begin
      occ <= 1'b1;
    end else if (take_left) begin
      occ <= left_entry.occ;
    end else if (cmd.pop) begin
      occ <= right_entry.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (take_new) begin
      data <= '{tm: cmd.tm, ident: cmd.ident, kind: cmd.kind};
    end else if (take_left) begin
      data <= left_entry.data;
    end else if (cmd.pop) begin
      data <= right_entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      match <= occ && (data.ident == cmd.ident) && (data.kind == KIND_TX);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/seq_or_tree.sv
// Registered OR reduction of the per-cell match flags.
`default_nettype none

module seq_or_tree (
  input  wire logic                            clk,
  input  wire logic                            enable,
  input  wire logic [seq_pkg::QUEUE_DEPTH-1:0] match,
  output logic                                 found
);
  import seq_pkg::*;

  logic [NUM_GROUPS-1:0] group_hit;
  logic [NUM_GROUPS-1:0] group_hit_next;

  always_comb begin
    group_hit_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < QUEUE_DEPTH) begin
          group_hit_next[g] = group_hit_next[g] | match[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      group_hit <= group_hit_next;
    end
  end

  assign found = |group_hit;

endmodule

`default_nettype wire

### hw/rtl/seq_chk.sv
// Port-level assertions for the sorted event queue, bound to the top level.
`default_nettype none

module seq_chk (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic [seq_pkg::IN_W-1:0]  s_tdata,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [seq_pkg::OUT_W-1:0] m_tdata
);
  import seq_pkg::*;

  out_word_t ow;

  assign ow = out_word_t'(m_tdata);

  // One word in flight: no second word is taken right after one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result word changed while stalled");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (ow.occupancy <= CNT_BITS'(QUEUE_DEPTH)))
    else $error("occupancy beyond queue depth");

  // No event reported means zeroed event fields and an empty queue.
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !ow.event_valid) |->
      (ow.event_time == '0 && ow.event_identity == '0 && !ow.event_kind
       && ow.occupancy == '0))
    else $error("event fields set with no event");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ow.status == ST_EMPTY) |-> (!ow.event_valid && !ow.found))
    else $error("empty pop reported an event");

endmodule

bind sorted_event_queue seq_chk u_seq_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
